### sv/bfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command/status types and helper functions of the frame allocator.
package bfa_pkg;

    localparam int NUM_FRAMES_DEF = 65536;
    localparam int FRAME_BYTES    = 4096;
    localparam int FRAME_SHIFT    = $clog2(FRAME_BYTES);
    localparam int FRAME_KB       = FRAME_BYTES / 1024;
    localparam int RES_W          = 17;
    localparam int KB_W           = 19;
    // frame number taken from a 32-bit byte address, and one bit more for limits
    localparam int FRN_W          = 32 - FRAME_SHIFT;
    localparam int FIDX_W         = FRN_W + 1;
    // word numbers are compared at this width
    localparam int PW             = 16;

    localparam logic [31:0]      ADDR_LIMIT   = 32'hFFFF_F000;
    localparam logic [31:0]      WORD_ONES    = 32'hFFFF_FFFF;
    localparam logic [RES_W-1:0] RESERVE_DEF  = RES_W'(32'h0010_0000 / FRAME_BYTES);

    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic open_prep1;
        logic open_prep2;
        logic rd;
        logic open_mod;
        logic alloc_take;
        logic word_inc;
        logic restart;
        logic free_take;
    } t_dp_cmd;

    typedef struct packed {
        logic region_ok;
        logic no_free;
        logic open_empty;
        logic open_last;
        logic word_full;
        logic word_last;
        logic hint_zero;
        logic frame_in_range;
    } t_dp_status;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        for (int i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

    // position of the lowest clear bit; 0 when none is clear
    function automatic logic [4:0] lowest_zero(input logic [31:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (!v[i]) idx = 5'(i);
        end
        return idx;
    endfunction

endpackage

### sv/bfa_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the frame allocator: clearing pass, region walk, next-fit scan and release.
module bfa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_kind,
    input  bfa_pkg::t_dp_status   i_status,
    output bfa_pkg::t_dp_cmd      o_cmd,
    output logic                  busy,
    output logic                  o_done
);
    import bfa_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_OPRE1 = 4'd2;
    localparam logic [3:0] S_OPRE2 = 4'd3;
    localparam logic [3:0] S_OCHK  = 4'd4;
    localparam logic [3:0] S_ORD   = 4'd5;
    localparam logic [3:0] S_OMOD  = 4'd6;
    localparam logic [3:0] S_OFIN  = 4'd7;
    localparam logic [3:0] S_ARD   = 4'd8;
    localparam logic [3:0] S_ACHK  = 4'd9;
    localparam logic [3:0] S_FRD   = 4'd10;
    localparam logic [3:0] S_FCHK  = 4'd11;
    localparam logic [3:0] S_RESP  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.word_last) n_state = S_IDLE;
            end
            S_IDLE, S_RESP: begin
                if (r_state == S_RESP) n_state = S_IDLE;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_second   = 1'b0;
                    unique case (i_kind)
                        KIND_OPEN:  n_state = i_status.region_ok ? S_OPRE1 : S_RESP;
                        KIND_ALLOC: n_state = i_status.no_free ? S_RESP : S_ARD;
                        KIND_FREE:  n_state = S_FRD;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_OPRE1: begin
                o_cmd.open_prep1 = 1'b1;
                n_state = S_OPRE2;
            end
            S_OPRE2: begin
                o_cmd.open_prep2 = 1'b1;
                n_state = S_OCHK;
            end
            S_OCHK: n_state = i_status.open_empty ? S_RESP : S_ORD;
            S_ORD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OMOD;
            end
            S_OMOD: begin
                o_cmd.open_mod = 1'b1;
                n_state = i_status.open_last ? S_OFIN : S_ORD;
            end
            // let the last word's counts settle
            S_OFIN: n_state = S_RESP;
            S_ARD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ACHK;
            end
            S_ACHK: begin
                priority if (!i_status.word_full) begin
                    o_cmd.alloc_take = 1'b1;
                    n_state = S_RESP;
                end else if (i_status.word_last) begin
                    // rescan once from word zero
                    if (!r_second && !i_status.hint_zero) begin
                        o_cmd.restart = 1'b1;
                        n_second = 1'b1;
                        n_state  = S_ARD;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    o_cmd.word_inc = 1'b1;
                    n_state = S_ARD;
                end
            end
            S_FRD: begin
                if (i_status.frame_in_range) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_FCHK;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_FCHK: begin
                o_cmd.free_take = 1'b1;
                n_state = S_RESP;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign busy   = (r_state != S_IDLE) && (r_state != S_RESP);
    assign o_done = (r_state == S_RESP);

endmodule

### sv/bfa_dpath.sv
`timescale 1ns / 1ps
// Bitmap memory, counters, hint and region bounds of the frame allocator.
module bfa_dpath #(
    parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfa_pkg::t_dp_cmd            i_cmd,
    output bfa_pkg::t_dp_status         o_status,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::RES_W-1:0]   i_cfg_wdata,
    input  logic [1:0]                  i_kind,
    input  logic [63:0]                 i_region_base,
    input  logic [63:0]                 i_region_length,
    input  logic                        i_region_is_usable,
    input  logic [31:0]                 i_frame_address,
    output logic [31:0]                 o_granted_address,
    output logic                        o_granted,
    output logic [bfa_pkg::KB_W-1:0]    o_free_kb,
    output logic [bfa_pkg::KB_W-1:0]    o_total_kb
);
    import bfa_pkg::*;

    localparam int WORDS = (NUM_FRAMES + 31) / 32;
    localparam int WW    = $clog2(WORDS);
    localparam int CW    = $clog2(NUM_FRAMES + 1);

    localparam logic [WW-1:0]     LAST_WORD = WW'(WORDS - 1);
    localparam logic [FIDX_W-1:0] N_FIDX    = FIDX_W'(NUM_FRAMES);
    localparam logic [CW:0]       N_SUM     = (CW+1)'(NUM_FRAMES);

    logic [31:0] mem [WORDS];
    logic [31:0] r_rdata;

    logic [WW-1:0]     r_word, r_hint;
    logic [CW-1:0]     r_free, r_usable;
    logic [5:0]        r_pop_use, r_pop_free;
    logic              r_pop_vld;
    logic [RES_W-1:0]  r_reserved;
    logic [31:0]       r_base, r_len, r_end;
    logic              r_len_big;
    logic [FRN_W-1:0]  r_fr;
    logic [FIDX_W-1:0] r_first, r_last;
    logic [31:0]       r_gaddr;
    logic              r_granted;

    logic [FIDX_W-1:0] last_m1;
    logic [PW-1:0]     w16, first_w, last_w, res_w;
    logic [32:0]       sum33;
    logic [31:0]       mask_lo, mask_hi, mask_res, used_in, clr_bits;
    logic [4:0]        zero_pos, fbit;
    logic              fbit_used;
    logic              we;
    logic [31:0]       wdata;
    logic [CW:0]       use_sum;
    logic [FRN_W-1:0]  end_fr;

    assign last_m1 = r_last - FIDX_W'(1);
    assign w16     = PW'(r_word);
    assign first_w = PW'(r_first[FIDX_W-1:5]);
    assign last_w  = PW'(last_m1[FIDX_W-1:5]);
    assign res_w   = PW'(r_reserved[RES_W-1:5]);
    assign sum33   = {1'b0, r_base} + {1'b0, r_len};
    assign end_fr  = r_end[31:FRAME_SHIFT];

    // frame masks of the word under update
    always_comb begin
        mask_lo = (w16 == first_w) ? (WORD_ONES << r_first[4:0]) : WORD_ONES;
        mask_hi = (w16 == last_w) ? (WORD_ONES >> (5'd31 - last_m1[4:0])) : WORD_ONES;
        priority if (w16 < res_w) mask_res = WORD_ONES;
        else if (w16 == res_w)    mask_res = ~(WORD_ONES << r_reserved[4:0]);
        else                      mask_res = '0;
        used_in  = r_rdata & mask_lo & mask_hi;
        clr_bits = used_in & ~mask_res;
    end

    assign zero_pos  = lowest_zero(r_rdata);
    assign fbit      = r_fr[4:0];
    assign fbit_used = r_rdata[fbit];

    always_comb begin
        we    = 1'b1;
        wdata = WORD_ONES;
        priority if (i_cmd.clr_step)  wdata = WORD_ONES;
        else if (i_cmd.open_mod)      wdata = r_rdata & ~clr_bits;
        else if (i_cmd.alloc_take)    wdata = r_rdata | (32'd1 << zero_pos);
        else if (i_cmd.free_take && fbit_used) wdata = r_rdata & ~(32'd1 << fbit);
        else                          we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[r_word] <= wdata;
        if (i_cmd.rd) r_rdata <= mem[r_word];
    end

    // latched item and region bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base    <= i_region_base[31:0];
            r_len     <= i_region_length[31:0];
            r_len_big <= i_region_length > {32'd0, ADDR_LIMIT};
            r_fr      <= i_frame_address[31:FRAME_SHIFT];
        end
        if (i_cmd.open_prep1) begin
            r_first <= FIDX_W'(r_base[31:FRAME_SHIFT]) + FIDX_W'(|r_base[FRAME_SHIFT-1:0]);
            priority if (r_len_big)         r_end <= ADDR_LIMIT;
            else if (sum33 > {1'b0, ADDR_LIMIT}) r_end <= ADDR_LIMIT;
            else                            r_end <= sum33[31:0];
        end
        if (i_cmd.open_prep2) begin
            r_last <= ({1'b0, end_fr} > N_FIDX) ? N_FIDX : {1'b0, end_fr};
        end
        if (i_cmd.open_mod) begin
            r_pop_use  <= popcount32(used_in);
            r_pop_free <= popcount32(clr_bits);
        end
    end

    assign use_sum = {1'b0, r_usable} + (CW+1)'(r_pop_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word     <= '0;
            r_hint     <= '0;
            r_free     <= '0;
            r_usable   <= '0;
            r_pop_vld  <= 1'b0;
            r_reserved <= RESERVE_DEF;
            r_gaddr    <= '0;
            r_granted  <= 1'b0;
        end else begin
            r_pop_vld <= i_cmd.open_mod;
            if (i_cfg_we) r_reserved <= i_cfg_wdata;
            if (r_pop_vld) begin
                r_free   <= r_free + CW'(r_pop_free);
                r_usable <= (use_sum > N_SUM) ? CW'(NUM_FRAMES) : CW'(use_sum);
            end
            priority if (i_cmd.load) begin
                r_gaddr   <= '0;
                r_granted <= 1'b0;
                unique case (i_kind)
                    KIND_FREE: r_word <= WW'(i_frame_address[31:FRAME_SHIFT+5]);
                    default:   r_word <= r_hint;
                endcase
            end else if (i_cmd.open_prep2) begin
                // start the region walk at the word of its first whole frame
                r_word <= WW'(r_first[FIDX_W-1:5]);
            end else if (i_cmd.clr_step) begin
                r_word <= (r_word == LAST_WORD) ? '0 : r_word + WW'(1);
            end else if (i_cmd.open_mod || i_cmd.word_inc) begin
                r_word <= r_word + WW'(1);
            end else if (i_cmd.restart) begin
                r_word <= '0;
                r_hint <= '0;
            end else if (i_cmd.alloc_take) begin
                if (r_free != '0) r_free <= r_free - CW'(1);
                r_hint    <= r_word;
                r_granted <= 1'b1;
                r_gaddr   <= 32'({r_word, zero_pos}) << FRAME_SHIFT;
            end else if (i_cmd.free_take && fbit_used) begin
                r_free <= r_free + CW'(1);
                if (r_word < r_hint) r_hint <= r_word;
            end
        end
    end

    always_comb begin
        o_status.region_ok      = i_region_is_usable && (i_region_base[63:32] == 32'd0);
        o_status.no_free        = (r_free == '0);
        o_status.open_empty     = (r_first >= r_last);
        o_status.open_last      = (w16 == last_w);
        o_status.word_full      = (r_rdata == WORD_ONES);
        o_status.word_last      = (r_word == LAST_WORD);
        o_status.hint_zero      = (r_hint == '0);
        o_status.frame_in_range = ({1'b0, r_fr} < N_FIDX);
    end

    assign o_granted_address = r_gaddr;
    assign o_granted         = r_granted;
    assign o_free_kb         = KB_W'(32'(r_free) * 32'(FRAME_KB));
    assign o_total_kb        = KB_W'(32'(r_usable) * 32'(FRAME_KB));

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(NUM_FRAMES))
        else $error("free frame count above frame total");

    a_usable_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_usable) <= 32'(NUM_FRAMES))
        else $error("usable frame count above frame total");

    a_take_has_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_take |-> (r_rdata != WORD_ONES))
        else $error("allocation taken from a full bitmap word");

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hint) < 32'(WORDS))
        else $error("hint word beyond bitmap");

endmodule

### sv/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// Top level of the bitmap frame allocator: sequencer and datapath.
//
// One bit per frame lives in a single-port bitmap RAM of (NUM_FRAMES+31)/32 words
// with a registered read; each bitmap word visited is read into a register, then
// checked or rewritten. After reset the block sweeps the RAM to all-used, holding
// busy high through the sweep; register writes are taken during the sweep. An item
// is taken when start is high and busy low. Open region goes straight to o_done
// when the region is skipped, stops after the bound checks when it holds no whole
// frame, and otherwise walks each bitmap word the region covers; allocate
// goes straight to o_done when no frame is free, else scans words from the hint,
// up to a full pass and a rescan from word zero; free reads the frame's word only
// when the frame is in range; anything else goes straight to o_done. Each item
// gives exactly one word on the result ports, marked by o_done for a single
// cycle; the receiver must take it then, as there is no stall. A new item may be
// started in the cycle o_done is high.
module bitmap_frame_allocator #(
    parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::RES_W-1:0]   i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_kind,
    input  logic [63:0]                 i_region_base,
    input  logic [63:0]                 i_region_length,
    input  logic                        i_region_is_usable,
    input  logic [31:0]                 i_frame_address,
    output logic                        o_done,
    output logic [31:0]                 o_granted_address,
    output logic                        o_granted,
    output logic [bfa_pkg::KB_W-1:0]    o_free_kb,
    output logic [bfa_pkg::KB_W-1:0]    o_total_kb
);
    import bfa_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    bfa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    bfa_dpath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_kind             (i_kind),
        .i_region_base      (i_region_base),
        .i_region_length    (i_region_length),
        .i_region_is_usable (i_region_is_usable),
        .i_frame_address    (i_frame_address),
        .o_granted_address  (o_granted_address),
        .o_granted          (o_granted),
        .o_free_kb          (o_free_kb),
        .o_total_kb         (o_total_kb)
    );

endmodule
